>>> design/ogim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogim_pkg
// Shared types and codes for the occupancy grid inflate and merge block.
// ----------------------------------------------------------------------------
package ogim_pkg;

	localparam logic [2:0] FUNC_LOAD    = 3'd0;
	localparam logic [2:0] FUNC_POINT   = 3'd1;
	localparam logic [2:0] FUNC_INFLATE = 3'd2;
	localparam logic [2:0] FUNC_READ    = 3'd3;
	localparam logic [2:0] FUNC_CLEAR   = 3'd4;

	localparam logic [1:0] CODE_UNKNOWN  = 2'd0;
	localparam logic [1:0] CODE_FREE     = 2'd1;
	localparam logic [1:0] CODE_OCCUPIED = 2'd2;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_CPM      = 3'd2;
	localparam logic [2:0] REG_RADIUS   = 3'd3;
	localparam logic [2:0] REG_OCC      = 3'd4;
	localparam logic [2:0] REG_FREE     = 3'd5;
	localparam logic [2:0] REG_WIDTH    = 3'd6;
	localparam logic [2:0] REG_HEIGHT   = 3'd7;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

endpackage

>>> design/ogim_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogim_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ogim_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> design/ogim_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogim_mul
// Shared 33 x 24 signed-by-unsigned multiplier with a registered product,
// used by the sequencer to map both coordinates of a point to cells.
// ----------------------------------------------------------------------------
module ogim_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic        [23:0] b,
	output logic signed [56:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= 57'(a * $signed({1'b0, b}));
	end
endmodule

>>> design/occupancy_grid_inflate_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_inflate_merge
// Static map plus point-cloud marks, disk inflation and merged cell reads.
// ----------------------------------------------------------------------------
// One item is handled at a time by a small sequencer. After reset a clearing
// pass zeroes the mark memories before the first item is taken. A point
// makes two passes through one shared multiplier. A read looks up the cell,
// then hands the word to the output register, where it waits without
// blocking later items unless another read needs the register. A clear
// walks the whole store, zeroing the mark memories. An inflate copies the
// marks into a snapshot memory and clears the result memory, then scans
// each active cell; each marked cell paints its disk one cell per cycle.
module occupancy_grid_inflate_merge #(
	parameter int GRID_WIDTH_MAX  = 256,
	parameter int GRID_HEIGHT_MAX = 256,
	parameter int RADIUS_MAX      = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// func[2:0], map_pixel[10:3], point_x[42:11], point_y[74:43],
	// cell_index[90:75], zero fill
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// cell_value[1:0], read_index[17:2], zero fill
	output logic [23:0] m_tdata,
	input  logic        cfg_we,
	input  logic [ogim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ogim_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ogim_pkg::*;

	localparam int XW    = $clog2(GRID_WIDTH_MAX);
	localparam int YW    = $clog2(GRID_HEIGHT_MAX);
	localparam int AW    = XW + YW;
	localparam int DEPTH = GRID_WIDTH_MAX * GRID_HEIGHT_MAX;
	localparam int RW    = $clog2(RADIUS_MAX + 1);
	localparam int OW    = RW + 2;       // signed offset -R..R
	localparam int CW    = ((XW > YW) ? XW : YW) + 2;  // signed coordinate with margin
	localparam int DW    = 2 * RW + 2;   // squared distances

	localparam logic [3:0] ST_INIT  = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_RD1   = 4'd2;
	localparam logic [3:0] ST_RD2   = 4'd3;
	localparam logic [3:0] ST_OUT   = 4'd4;
	localparam logic [3:0] ST_PX    = 4'd5;
	localparam logic [3:0] ST_PY    = 4'd6;
	localparam logic [3:0] ST_PW    = 4'd7;
	localparam logic [3:0] ST_CLR   = 4'd8;
	localparam logic [3:0] ST_COPY  = 4'd9;
	localparam logic [3:0] ST_ICLR  = 4'd10;
	localparam logic [3:0] ST_SCAN  = 4'd11;
	localparam logic [3:0] ST_SCANW = 4'd12;
	localparam logic [3:0] ST_PAINT = 4'd13;
	localparam logic [3:0] ST_PX2   = 4'd14;
	localparam logic [3:0] ST_LOAD  = 4'd15;

	// configuration
	logic signed [31:0] org_x_q, org_y_q;
	logic [23:0] cpm_q;
	logic [3:0]  rad_q;
	logic [7:0]  occ_q, free_q;
	logic [8:0]  gw_q, gh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			cpm_q   <= 24'd81920;
			rad_q   <= 4'd3;
			occ_q   <= 8'd10;
			free_q  <= 8'd250;
			gw_q    <= 9'd256;
			gh_q    <= 9'd256;
		end else if (cfg_we && cfg_index[3] == 1'b0) begin
			case (cfg_index[2:0])
				REG_ORIGIN_X: org_x_q <= cfg_data;
				REG_ORIGIN_Y: org_y_q <= cfg_data;
				REG_CPM:      cpm_q   <= cfg_data[23:0];
				REG_RADIUS:   rad_q   <= cfg_data[3:0];
				REG_OCC:      occ_q   <= cfg_data[7:0];
				REG_FREE:     free_q  <= cfg_data[7:0];
				REG_WIDTH:    gw_q    <= cfg_data[8:0];
				REG_HEIGHT:   gh_q    <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// active sizes, saturated
	logic [XW:0] w_act;
	logic [YW:0] h_act;
	logic [RW-1:0] r_act;
	always_comb begin
		if (gw_q == 9'd0) w_act = (XW+1)'(1);
		else if (32'(gw_q) > GRID_WIDTH_MAX) w_act = (XW+1)'(GRID_WIDTH_MAX);
		else w_act = (XW+1)'(gw_q);
		if (gh_q == 9'd0) h_act = (YW+1)'(1);
		else if (32'(gh_q) > GRID_HEIGHT_MAX) h_act = (YW+1)'(GRID_HEIGHT_MAX);
		else h_act = (YW+1)'(gh_q);
		if (32'(rad_q) > RADIUS_MAX) r_act = RW'(RADIUS_MAX);
		else r_act = RW'(rad_q);
	end

	logic [AW:0] cells;
	assign cells = (AW+1)'(w_act * h_act);

	// state
	logic [3:0]  st_q;
	logic [AW:0] ctr_q;        // sweep counter
	logic [AW-1:0] lp_q;       // load pointer
	logic [AW-1:0] lp_eff;     // load pointer, back to cell 0 when the grid shrank
	logic [XW:0] sx_q;         // scan column
	logic [YW:0] sy_q;         // scan row
	logic signed [OW-1:0] dx_q, dy_q;
	logic [7:0]  pix_q;
	logic signed [31:0] px_q, py_q;
	logic [15:0] ridx_q;
	logic [1:0]  val_q;
	logic signed [56:0] cx_q;
	logic signed [56:0] prod;
	logic signed [32:0] mul_a;
	logic        out_load;
	logic [1:0]  out_val_q;
	logic [15:0] out_idx_q;

	assign lp_eff = ((AW+1)'(lp_q) >= cells) ? '0 : lp_q;

	ogim_mul u_mul (.clk(clk), .a(mul_a), .b(cpm_q), .p_q(prod));
	assign mul_a = (st_q == ST_PX) ? (33'(px_q) - 33'(org_x_q)) : (33'(py_q) - 33'(org_y_q));

	// memories
	logic map_we, cl_we, inf_we, snp_we;
	logic [AW-1:0] map_wa, cl_wa, inf_wa, snp_wa, map_ra, cl_ra, inf_ra, snp_ra;
	logic [1:0] map_wd, map_rd;
	logic cl_wd, inf_wd, snp_wd, cl_rd, inf_rd, snp_rd;

	ogim_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_map (.clk(clk), .we(map_we), .waddr(map_wa),
		.wdata(map_wd), .raddr(map_ra), .rdata(map_rd));
	ogim_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_cloud (.clk(clk), .we(cl_we), .waddr(cl_wa),
		.wdata(cl_wd), .raddr(cl_ra), .rdata(cl_rd));
	ogim_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_infl (.clk(clk), .we(inf_we), .waddr(inf_wa),
		.wdata(inf_wd), .raddr(inf_ra), .rdata(inf_rd));
	ogim_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_snap (.clk(clk), .we(snp_we), .waddr(snp_wa),
		.wdata(snp_wd), .raddr(snp_ra), .rdata(snp_rd));

	// truncation toward zero of a Q28.28 product
	function automatic logic signed [28:0] trunc28(input logic signed [56:0] v);
		logic signed [56:0] t;
		t = v + ((v < 0) ? 57'sd268435455 : 57'sd0);
		return t[56:28];
	endfunction

	logic signed [28:0] cx_t, cy_t;
	assign cx_t = trunc28(cx_q);
	assign cy_t = trunc28(prod);

	// disk paint target
	logic signed [CW-1:0] nx, ny;
	logic [DW-1:0] dd, rr;
	logic in_disk, in_grid;
	assign nx = CW'($signed({1'b0, sx_q})) + CW'(dx_q);
	assign ny = CW'($signed({1'b0, sy_q})) + CW'(dy_q);
	assign dd = DW'(dx_q * dx_q) + DW'(dy_q * dy_q);
	assign rr = DW'(r_act * r_act);
	assign in_disk = dd <= rr;
	assign in_grid = nx >= 0 && ny >= 0 && nx < CW'(w_act) && ny < CW'(h_act);

	logic [AW-1:0] scan_a, paint_a;
	assign scan_a  = AW'(sy_q * w_act + sx_q);
	assign paint_a = AW'(ny * CW'(w_act) + nx);

	logic [2:0]  in_func;
	logic [15:0] in_idx;
	assign in_func = s_tdata[2:0];
	assign in_idx  = s_tdata[90:75];
	assign s_tready = (st_q == ST_IDLE);

	logic last_dx, last_dy;
	assign last_dx = dx_q == OW'(r_act);
	assign last_dy = dy_q == OW'(r_act);

	always_comb begin
		map_we = 1'b0; map_wa = lp_eff; map_wd = CODE_UNKNOWN;
		cl_we = 1'b0;  cl_wa = ctr_q[AW-1:0]; cl_wd = 1'b0;
		inf_we = 1'b0; inf_wa = ctr_q[AW-1:0]; inf_wd = 1'b0;
		snp_we = 1'b0; snp_wa = ctr_q[AW-1:0]; snp_wd = 1'b0;
		map_ra = ridx_q[AW-1:0]; cl_ra = ridx_q[AW-1:0]; inf_ra = ridx_q[AW-1:0];
		snp_ra = scan_a;
		case (st_q)
			ST_INIT, ST_CLR: begin
				cl_we = 1'b1; inf_we = 1'b1;
			end
			ST_LOAD: begin
				map_we = 1'b1;
				if (pix_q <= occ_q) map_wd = CODE_OCCUPIED;
				else if (pix_q >= free_q) map_wd = CODE_FREE;
			end
			ST_PW: begin
				cl_wa = AW'(cy_t * 29'(w_act) + cx_t);
				cl_we = cx_t >= 0 && cy_t >= 0 && cx_t < 29'(w_act) && cy_t < 29'(h_act);
				cl_wd = 1'b1;
			end
			ST_COPY: begin
				// read one ahead; ctr_q is the write address, read address is ctr+1
				cl_ra = AW'(ctr_q + 1'b1); inf_ra = AW'(ctr_q + 1'b1);
				snp_we = ctr_q != '1 && ctr_q[AW] == 1'b0;
				snp_wd = cl_rd | inf_rd;
			end
			ST_ICLR: inf_we = 1'b1;
			ST_PAINT: begin
				inf_we = in_disk && in_grid; inf_wa = paint_a; inf_wd = 1'b1;
			end
			default: ;
		endcase
		if (st_q == ST_COPY && ctr_q == '1) begin
			cl_ra = '0; inf_ra = '0;
		end
	end

	// hand the read result to the output register once it is free
	assign out_load = (st_q == ST_OUT) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_INIT; ctr_q <= '0; lp_q <= '0;
		end else begin
			case (st_q)
				ST_INIT, ST_CLR, ST_ICLR: begin
					ctr_q <= ctr_q + 1'b1;
					if (ctr_q == (AW+1)'(DEPTH - 1)) begin
						ctr_q <= '0;
						if (st_q == ST_ICLR) begin
							st_q <= ST_SCAN; sx_q <= '0; sy_q <= '0;
						end else st_q <= ST_IDLE;
					end
				end
				ST_IDLE: if (s_tvalid) begin
					pix_q <= s_tdata[10:3];
					px_q <= s_tdata[42:11];
					py_q <= s_tdata[74:43];
					ridx_q <= in_idx;
					ctr_q <= '0;
					case (in_func)
						FUNC_LOAD:    st_q <= ST_LOAD;
						FUNC_POINT:   st_q <= ST_PX;
						FUNC_INFLATE: begin st_q <= ST_COPY; ctr_q <= '1; end
						FUNC_READ:    st_q <= ST_RD1;
						FUNC_CLEAR:   st_q <= ST_CLR;
						default: ;
					endcase
				end
				ST_LOAD: begin
					if ((AW+1)'(lp_eff) >= cells - 1'b1) lp_q <= '0;
					else lp_q <= lp_eff + 1'b1;
					st_q <= ST_IDLE;
				end
				ST_PX: st_q <= ST_PX2;
				ST_PX2: begin cx_q <= prod; st_q <= ST_PY; end
				ST_PY: st_q <= ST_PW;
				ST_PW: st_q <= ST_IDLE;
				ST_RD1: st_q <= ST_RD2;
				ST_RD2: begin
					if ((AW+1)'(ridx_q) >= cells || 32'(ridx_q) >= DEPTH) val_q <= CODE_UNKNOWN;
					else if (cl_rd | inf_rd) val_q <= CODE_OCCUPIED;
					else if (map_rd == CODE_OCCUPIED) val_q <= CODE_OCCUPIED;
					else if (map_rd == CODE_FREE) val_q <= CODE_FREE;
					else val_q <= CODE_UNKNOWN;
					st_q <= ST_OUT;
				end
				ST_OUT: if (out_load) st_q <= ST_IDLE;
				ST_COPY: begin
					ctr_q <= ctr_q + 1'b1;
					if (ctr_q == (AW+1)'(DEPTH - 1)) begin
						ctr_q <= '0; st_q <= ST_ICLR;
					end
				end
				ST_SCAN: st_q <= ST_SCANW;
				ST_SCANW: begin
					if (snp_rd) begin
						dx_q <= -OW'(r_act); dy_q <= -OW'(r_act); st_q <= ST_PAINT;
					end else if (sx_q == w_act - 1'b1) begin
						sx_q <= '0;
						if (sy_q == h_act - 1'b1) st_q <= ST_IDLE;
						else begin sy_q <= sy_q + 1'b1; st_q <= ST_SCAN; end
					end else begin
						sx_q <= sx_q + 1'b1; st_q <= ST_SCAN;
					end
				end
				ST_PAINT: begin
					if (!last_dx) dx_q <= dx_q + 1'b1;
					else begin
						dx_q <= -OW'(r_act);
						if (!last_dy) dy_q <= dy_q + 1'b1;
						else if (sx_q == w_act - 1'b1) begin
							sx_q <= '0;
							if (sy_q == h_act - 1'b1) st_q <= ST_IDLE;
							else begin sy_q <= sy_q + 1'b1; st_q <= ST_SCAN; end
						end else begin
							sx_q <= sx_q + 1'b1; st_q <= ST_SCAN;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0; out_val_q <= '0; out_idx_q <= '0;
		end else if (out_load) begin
			m_tvalid <= 1'b1; out_val_q <= val_q; out_idx_q <= ridx_q;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	assign m_tdata = {6'd0, out_idx_q, out_val_q};

`ifndef ASSERT_OFF
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");
	a_val_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3) else $error("bad cell code");
	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(st_q) == ST_OUT) else $error("result without read");
`endif
endmodule
